// ===== hdl/whitespace_line_breaker_macros.svh =====
// assertion macros used by the line breaker checker
`ifndef WHITESPACE_LINE_BREAKER_MACROS_SVH
`define WHITESPACE_LINE_BREAKER_MACROS_SVH

// condition holds in the same cycle
`define WLB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define WLB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/wlb_pkg.sv =====
// types and constants of the whitespace line breaker
package wlb_pkg;

	localparam int LEN_W = 7;

	localparam logic [LEN_W-1:0] MIN_LEN = 7'd17;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic REG_LINE_LENGTH = 1'b0;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

endpackage

// ===== hdl/whitespace_line_breaker.sv =====
// whitespace line breaker: greedy word wrap on a text byte stream
//
// input channel in_valid/in_stall/in_data: one text byte or an end marker per
// transfer. output channel out_valid/out_stall/out_data: the wrapped stream,
// one byte per transfer, last set on the final byte that an input item causes.
// the apb port holds line_length at address 0; values are clamped to
// 17 .. HOLD_DEPTH-2.
//
// bytes after the latest blank of a line wait in a single-port hold memory
// (one write or one read per cycle, read data registered). a text byte that is
// only held is written on its transfer. an item that emits bytes is decoded
// first, then each held byte flushed is read and loaded, then each inserted
// byte (the blank, cr, lf, or the newline itself) is loaded; held bytes lead.
//
// in_stall is high while an item's bytes are being sent. a stalled output
// register freezes the sequencer; the input side keeps stalling meanwhile.
// reset clears counts and flags; the hold memory needs no clearing since only
// entries below the fill count are read.
module whitespace_line_breaker #(
	parameter int HOLD_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wlb_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wlb_pkg::out_item_t   out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int CNT_W  = $clog2(HOLD_DEPTH + 1);
	localparam int ADDR_W = $clog2(HOLD_DEPTH);
	localparam int LEN_W  = wlb_pkg::LEN_W;
	localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(HOLD_DEPTH - 2);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;
	localparam logic [1:0] S_TAIL = 2'd3;

	logic [1:0]       state_q;
	logic [LEN_W-1:0] line_length_q;
	logic [CNT_W-1:0] held_count_q, line_count_q;
	logic             blank_seen_q, break_inserted_q, first_cr_q;
	logic [CNT_W-1:0] flush_n_q, idx_q;
	logic [1:0]       tail_n_q;
	logic [2:0][7:0]  tail_q;
	logic             out_valid_q;
	wlb_pkg::out_item_t out_data_q;

	// hold memory
	logic [7:0] hold_mem [HOLD_DEPTH];
	logic [7:0] rd_q;
	logic       mem_we;

	logic             accept, adv, cfg_wr, load_out;
	logic [LEN_W-1:0] len;
	logic [CNT_W-1:0] lc_inc, hc_inc;
	logic             trig, is_blank, is_lf, drop_crlf;

	logic [CNT_W-1:0] n_held, n_line, n_flush;
	logic             n_blank, n_brk;
	logic [1:0]       n_tail_n;
	logic [2:0][7:0]  n_tail;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign adv       = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	// a byte moves into the output register this cycle
	assign load_out  = ((state_q == S_HOLD) || (state_q == S_TAIL)) && adv;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == wlb_pkg::REG_LINE_LENGTH) ?
		{{(32 - LEN_W){1'b0}}, line_length_q} : 32'd0;

	// clamp the configured length
	always_comb begin
		priority if (line_length_q < wlb_pkg::MIN_LEN) begin
			len = wlb_pkg::MIN_LEN;
		end else if (line_length_q > MaxLen) begin
			len = MaxLen;
		end else begin
			len = line_length_q;
		end
	end

	assign lc_inc    = line_count_q + 1'b1;
	assign hc_inc    = held_count_q + 1'b1;
	assign trig      = CMP_W'(lc_inc) >= CMP_W'(len);
	assign is_blank  = (in_data.in_byte == wlb_pkg::CH_SPACE) ||
		(in_data.in_byte == wlb_pkg::CH_TAB);
	assign is_lf     = (in_data.in_byte == wlb_pkg::CH_LF);
	// a lone cr+lf line right after an inserted break
	assign drop_crlf = break_inserted_q && (line_count_q == CNT_W'(1)) &&
		(held_count_q == CNT_W'(1)) && first_cr_q;

	// decode of one item: next line state, bytes to flush and tail bytes
	always_comb begin
		n_held   = held_count_q;
		n_line   = line_count_q;
		n_blank  = blank_seen_q;
		n_brk    = break_inserted_q;
		n_flush  = '0;
		n_tail_n = 2'd0;
		n_tail   = '0;
		mem_we   = 1'b0;
		priority if (in_data.kind == wlb_pkg::KIND_END) begin
			n_flush = held_count_q;
			n_held  = '0;
			n_line  = '0;
			n_blank = 1'b0;
			n_brk   = 1'b0;
		end else if (is_lf) begin
			if (drop_crlf) begin
				n_brk = 1'b0;
			end else begin
				n_flush   = held_count_q;
				n_tail[0] = wlb_pkg::CH_LF;
				n_tail_n  = 2'd1;
			end
			n_held  = '0;
			n_line  = '0;
			n_blank = 1'b0;
		end else if (is_blank) begin
			n_flush   = held_count_q;
			n_tail[0] = in_data.in_byte;
			n_held    = '0;
			if (trig) begin
				n_tail[1] = wlb_pkg::CH_CR;
				n_tail[2] = wlb_pkg::CH_LF;
				n_tail_n  = 2'd3;
				n_line    = '0;
				n_blank   = 1'b0;
				n_brk     = 1'b1;
			end else begin
				n_tail_n = 2'd1;
				n_line   = lc_inc;
				n_blank  = 1'b1;
			end
		end else begin
			mem_we = 1'b1;
			if (trig && blank_seen_q) begin
				// break at the latest blank, held bytes start the new line
				n_tail[0] = wlb_pkg::CH_CR;
				n_tail[1] = wlb_pkg::CH_LF;
				n_tail_n  = 2'd2;
				n_held    = hc_inc;
				n_line    = hc_inc;
				n_blank   = 1'b0;
				n_brk     = 1'b1;
			end else if (trig) begin
				// no blank in the line: flush it unbroken
				n_flush = hc_inc;
				n_held  = '0;
				n_line  = '0;
				n_blank = 1'b0;
				n_brk   = 1'b0;
			end else begin
				n_held = hc_inc;
				n_line = lc_inc;
			end
		end
	end

	// hold memory: write on accept, registered read in the read state
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			hold_mem[held_count_q[ADDR_W-1:0]] <= in_data.in_byte;
		end
		if (state_q == S_READ) begin
			rd_q <= hold_mem[idx_q[ADDR_W-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			line_length_q    <= LEN_W'(64);
			held_count_q     <= '0;
			line_count_q     <= '0;
			blank_seen_q     <= 1'b0;
			break_inserted_q <= 1'b0;
			first_cr_q       <= 1'b0;
			flush_n_q        <= '0;
			idx_q            <= '0;
			tail_n_q         <= 2'd0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == wlb_pkg::REG_LINE_LENGTH)) begin
				line_length_q <= pwdata[LEN_W-1:0];
			end

			// valid stays while stalled, or comes up with a new byte
			out_valid_q <= load_out || (out_valid_q && out_stall);

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						held_count_q     <= n_held;
						line_count_q     <= n_line;
						blank_seen_q     <= n_blank;
						break_inserted_q <= n_brk;
						flush_n_q        <= n_flush;
						tail_n_q         <= n_tail_n;
						idx_q            <= '0;
						if (mem_we && (held_count_q == '0)) begin
							first_cr_q <= (in_data.in_byte == wlb_pkg::CH_CR);
						end
						if (n_flush != '0) begin
							state_q <= S_READ;
						end else if (n_tail_n != 2'd0) begin
							state_q <= S_TAIL;
						end
					end
				end
				S_READ: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (adv) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q + 1'b1 != flush_n_q) begin
							state_q <= S_READ;
						end else if (tail_n_q != 2'd0) begin
							state_q <= S_TAIL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_TAIL: begin
					if (adv) begin
						tail_n_q <= tail_n_q - 1'b1;
						if (tail_n_q == 2'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: tail bytes shift toward slot 0, output register
	always_ff @(posedge clk) begin
		if (accept) begin
			tail_q <= n_tail;
		end
		if (state_q == S_HOLD && adv) begin
			out_data_q.out_byte <= rd_q;
			out_data_q.last     <= (idx_q + 1'b1 == flush_n_q) && (tail_n_q == 2'd0);
		end else if (state_q == S_TAIL && adv) begin
			out_data_q.out_byte <= tail_q[0];
			out_data_q.last     <= (tail_n_q == 2'd1);
			tail_q[0]           <= tail_q[1];
			tail_q[1]           <= tail_q[2];
		end
	end

endmodule

// ===== hdl/wlb_checker.sv =====
// port checker for the whitespace line breaker and its bind
`include "whitespace_line_breaker_macros.svh"

module wlb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input wlb_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input wlb_pkg::out_item_t out_data,
	input logic               psel,
	input logic               pready
);

	logic blank_in;

	assign blank_in = in_valid && !in_stall && (in_data.kind == wlb_pkg::KIND_TEXT) &&
		((in_data.in_byte == wlb_pkg::CH_SPACE) || (in_data.in_byte == wlb_pkg::CH_TAB));

	// stalled output transfer holds
	`WLB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output changed under stall")

	// a blank always produces bytes, so the input side stalls next
	`WLB_ASSERT_NEXT(a_blank_busy, blank_in, in_stall, "blank accepted without output run")

	// more bytes of the item pending, so no new item may enter
	`WLB_ASSERT_NOW(a_run_stall, out_valid && !out_data.last, in_stall, "input open mid run")

	// config port never waits
	`WLB_ASSERT_NOW(a_pready, psel, pready, "pready low")

endmodule

bind whitespace_line_breaker wlb_checker u_wlb_checker (.*);

// ===== tb/whitespace_line_breaker_tb.sv =====
// self-checking testbench of the whitespace line breaker
`timescale 1ns / 100ps

module whitespace_line_breaker_tb;

	localparam int HOLD_DEPTH  = 64;
	localparam int REG_SPARE   = 1;       // no register behind this index
	localparam int HOLD_CYCLES = 300;     // long receiver hold-off
	localparam int DRAIN       = 12;      // cycles the block may still be busy
	localparam int CYCLE_LIMIT = 200000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	wlb_pkg::in_item_t   in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	wlb_pkg::out_item_t  out_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	whitespace_line_breaker #(
		.HOLD_DEPTH(HOLD_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 2 ns clock
	initial begin
		forever #1 clk = ~clk;
	end

	// stimulus queue and traffic knobs, owned by the sequence below
	wlb_pkg::in_item_t text_q[$];
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	bit       hold_arm = 1'b0;

	// bookkeeping
	int pushed_cnt = 0;
	int taken_cnt = 0;
	int checked_cnt = 0;
	int err_cnt = 0;
	int break_cnt = 0;
	int dropped_cnt = 0;
	int setting_cnt = 0;
	int cycle_cnt = 0;
	bit in_took = 1'b0;

	// predictor state: line length register and the wrap state of the stream
	logic [6:0] wrap_len_reg = 7'd64;
	logic [7:0] held_mem [HOLD_DEPTH];
	int         held_cnt = 0;
	int         line_cnt = 0;
	bit         blank_flag = 1'b0;
	bit         brk_flag = 1'b0;
	wlb_pkg::out_item_t step_out[$];
	wlb_pkg::out_item_t wrapped_q[$];
	wlb_pkg::out_item_t want_item;

	// one output byte of the current item; never more than the hold depth
	function automatic void put_byte(logic [7:0] b);
		wlb_pkg::out_item_t o;
		if (step_out.size() < HOLD_DEPTH) begin
			o.out_byte = b;
			o.last = 1'b0;
			step_out.push_back(o);
		end
	endfunction

	function automatic void flush_held();
		for (int i = 0; i < held_cnt; i++)
			put_byte(held_mem[i]);
		held_cnt = 0;
	endfunction

	function automatic void clear_line();
		held_cnt = 0;
		line_cnt = 0;
		blank_flag = 1'b0;
	endfunction

	// expected wrapped bytes for one accepted input item
	function automatic void wrap_item(wlb_pkg::in_item_t it);
		int                 lim;
		wlb_pkg::out_item_t o;
		lim = wrap_len_reg;
		if (lim < wlb_pkg::MIN_LEN)
			lim = wlb_pkg::MIN_LEN;
		if (lim > HOLD_DEPTH - 2)
			lim = HOLD_DEPTH - 2;
		step_out.delete();
		if (it.kind == wlb_pkg::KIND_END) begin
			// end of stream: flush and start over, byte ignored
			flush_held();
			clear_line();
			brk_flag = 1'b0;
		end else if (it.in_byte == wlb_pkg::CH_LF) begin
			// a lone cr-lf right after an inserted break is swallowed
			if (brk_flag && line_cnt == 1 && held_cnt == 1 &&
				held_mem[0] == wlb_pkg::CH_CR) begin
				brk_flag = 1'b0;
				dropped_cnt++;
			end else begin
				flush_held();
				put_byte(wlb_pkg::CH_LF);
			end
			clear_line();
		end else if (it.in_byte == wlb_pkg::CH_SPACE || it.in_byte == wlb_pkg::CH_TAB) begin
			flush_held();
			put_byte(it.in_byte);
			blank_flag = 1'b1;
			line_cnt++;
			if (line_cnt >= lim) begin
				put_byte(wlb_pkg::CH_CR);
				put_byte(wlb_pkg::CH_LF);
				clear_line();
				brk_flag = 1'b1;
				break_cnt++;
			end
		end else begin
			if (held_cnt < HOLD_DEPTH) begin
				held_mem[held_cnt] = it.in_byte;
				held_cnt++;
			end
			line_cnt++;
			if (line_cnt >= lim) begin
				if (blank_flag) begin
					// break after the last blank, held word moves to the new line
					put_byte(wlb_pkg::CH_CR);
					put_byte(wlb_pkg::CH_LF);
					line_cnt = held_cnt;
					blank_flag = 1'b0;
					brk_flag = 1'b1;
					break_cnt++;
				end else begin
					// no blank on the line: goes out unbroken
					flush_held();
					clear_line();
					brk_flag = 1'b0;
				end
			end
		end
		if (step_out.size() != 0) begin
			o = step_out.pop_back();
			o.last = 1'b1;
			step_out.push_back(o);
		end
		foreach (step_out[i])
			wrapped_q.push_back(step_out[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	// driver: presents the next pending item at the falling edge,
	// holds a stalled transfer unchanged
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// transfer still pending, payload stays put
		end else if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			in_valid <= 1'b1;
			in_data <= text_q.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// long receiver hold-off, counted here so the sender keeps offering meanwhile
	int hold_left = 0;
	bit hold_fired = 1'b0;
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_fired) begin
			hold_left <= HOLD_CYCLES;
			hold_fired <= 1'b1;
		end
	end

	// receiver stall, random plus the hold-off
	always @(negedge clk) begin
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: predicts on each input transfer, checks each output transfer
	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken_cnt++;
				wrap_item(in_data);
			end
			if (out_valid && !out_stall) begin
				checked_cnt++;
				if (wrapped_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b",
						out_data.out_byte, out_data.last));
				end else begin
					want_item = wrapped_q.pop_front();
					if (out_data.out_byte !== want_item.out_byte)
						report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
							checked_cnt, out_data.out_byte, want_item.out_byte));
					if (out_data.last !== want_item.last)
						report_mismatch($sformatf("byte %0d: last %0b, want %0b",
							checked_cnt, out_data.last, want_item.last));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still owed", cycle_cnt,
				wrapped_q.size());
			$display("[whitespace_line_breaker] ERROR");
			$finish;
		end
	end

	// apb write: setup cycle, access cycle, register taken when pready is high
	task automatic apb_write(input int idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 3'(idx * 4);
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == wlb_pkg::REG_LINE_LENGTH) begin
			wrap_len_reg = val[6:0];
			setting_cnt++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic push_item(input logic kind, input logic [7:0] b);
		wlb_pkg::in_item_t it;
		it.kind = kind;
		it.in_byte = b;
		text_q.push_back(it);
		pushed_cnt++;
	endtask

	// mostly words and blanks with line ends, plus some raw noise
	task automatic push_random(input int n);
		int start;
		int r;
		int wlen;
		start = pushed_cnt;
		while (pushed_cnt - start < n) begin
			r = $urandom_range(99);
			if (r < 55) begin
				wlen = $urandom_range(1, 12);
				for (int i = 0; i < wlen; i++)
					push_item(wlb_pkg::KIND_TEXT, 8'($urandom_range(8'h21, 8'hff)));
				push_item(wlb_pkg::KIND_TEXT,
					($urandom_range(3) == 0) ? wlb_pkg::CH_TAB : wlb_pkg::CH_SPACE);
			end else if (r < 65) begin
				push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_CR);
				push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_LF);
			end else if (r < 70) begin
				push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_LF);
			end else if (r < 73) begin
				push_item(wlb_pkg::KIND_END, 8'($urandom_range(255)));
			end else if (r < 80) begin
				// long word, longer than a line at short lengths, can force an unbroken flush
				wlen = $urandom_range(20, 70);
				for (int i = 0; i < wlen; i++)
					push_item(wlb_pkg::KIND_TEXT, 8'($urandom_range(8'h21, 8'hff)));
			end else begin
				push_item(($urandom_range(15) == 0) ? wlb_pkg::KIND_END : wlb_pkg::KIND_TEXT,
					8'($urandom_range(255)));
			end
		end
	endtask

	// wait until every item is taken and every byte has come, then let the block go quiet
	task automatic settle();
		while (taken_cnt != pushed_cnt || wrapped_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN)
			@(negedge clk);
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, length written below the floor
		apb_write(wlb_pkg::REG_LINE_LENGTH, 32'd0);
		push_item(wlb_pkg::KIND_TEXT, 8'h00);
		push_item(wlb_pkg::KIND_TEXT, 8'hff);
		push_item(wlb_pkg::KIND_END, 8'hff);
		// a full line ending in a blank, tab inside it
		for (int i = 0; i < 16; i++)
			push_item(wlb_pkg::KIND_TEXT, (i == 7) ? wlb_pkg::CH_TAB : 8'(8'h41 + i));
		push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_SPACE);
		// cr-lf line right after the break is dropped, the next newline is not
		push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_CR);
		push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_LF);
		push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_LF);
		push_item(wlb_pkg::KIND_END, 8'h00);
		settle();

		// no idling, length far above the cap with junk in the upper data bits,
		// and a write to an unused index
		apb_write(wlb_pkg::REG_LINE_LENGTH, {25'($urandom), 7'd127});
		apb_write(REG_SPARE, $urandom);
		push_random(20);
		settle();

		// sender idle about half the time
		apb_write(wlb_pkg::REG_LINE_LENGTH, 32'd40);
		send_idle_pct = 51;
		recv_stall_pct = 0;
		push_random(20);
		settle();

		// receiver stalls about half the time, plus one long hold-off
		apb_write(wlb_pkg::REG_LINE_LENGTH, 32'd63);
		send_idle_pct = 0;
		recv_stall_pct = 51;
		hold_arm = 1'b1;
		push_random(20);
		// leave a long line open: blank early, long word after it
		push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_LF);
		for (int i = 0; i < 4; i++)
			push_item(wlb_pkg::KIND_TEXT, 8'h61);
		push_item(wlb_pkg::KIND_TEXT, wlb_pkg::CH_SPACE);
		for (int i = 0; i < 25; i++)
			push_item(wlb_pkg::KIND_TEXT, 8'(8'h62 + i));
		settle();

		// length cut to the minimum mid-line, both sides idling
		apb_write(wlb_pkg::REG_LINE_LENGTH, 32'd17);
		send_idle_pct = 19;
		recv_stall_pct = 19;
		push_item(wlb_pkg::KIND_TEXT, 8'h7a);
		push_item(wlb_pkg::KIND_TEXT, 8'h7a);
		push_random(20);
		settle();

		if (wrapped_q.size() != 0)
			report_mismatch($sformatf("%0d bytes never came out", wrapped_q.size()));

		$display("wrapped %0d input transfers into %0d output transfers at %0d length settings",
			taken_cnt, checked_cnt, setting_cnt);
		$display("%0d breaks inserted, %0d cr-lf lines dropped, %0d mismatches",
			break_cnt, dropped_cnt, err_cnt);
		if (err_cnt == 0) begin
			$display("[whitespace_line_breaker] OK");
		end else begin
			$display("[whitespace_line_breaker] ERROR");
		end
		$finish;
	end

endmodule
